// ===== src/pabq_pkg.sv =====
// ----------------------------------------------------------------------------
// pabq_pkg: shared definitions for the priority-aware bounded queue
// Command and status codes, field widths, register indexes, reset values and
// the structs that travel along the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pabq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int IN_PAY_W   = 32;
  localparam int SIZE_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int OCC_W      = 5;
  localparam int BYTES_W    = 24;
  localparam int DROPS_W    = 32;
  localparam int ILIMIT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 3;

  localparam int ITEM_LIMIT_RST = 16;
  localparam int BYTE_LIMIT_RST = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_OPEN  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_CLOSED       = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_NO_ROOM      = 3'd3,
    ST_EMPTY_OPEN   = 3'd4,
    ST_EMPTY_CLOSED = 3'd5
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic              evict_np;  // remove the oldest ordinary entry
    logic [SIZE_W-1:0] wr_size;
    logic              wr_prio;
  } cell_ctl_t;

  // Passed from each cell to the next one toward the tail.
  typedef struct packed {
    logic              np_seen;   // an ordinary entry sits nearer the head
    logic              shift;     // this cell and all behind it move up
    logic [SIZE_W-1:0] rm_size;   // size of the entry being removed
  } cell_link_t;

endpackage

`default_nettype wire

// ===== src/pabq_cell.sv =====
// ----------------------------------------------------------------------------
// pabq_cell: one storage cell of the queue row
// Holds one entry. On a removal at or ahead of this cell it takes the entry
// of its neighbor toward the tail; it also marks itself as the eviction
// victim when it is the oldest ordinary entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pabq_cell #(
  parameter int PAYLOAD_WIDTH = pabq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire  pabq_pkg::cell_ctl_t      ctl,
  input  wire                            valid_i,
  input  wire                            wr_i,
  input  wire  [PAYLOAD_WIDTH-1:0]       wr_payload,
  input  wire  [PAYLOAD_WIDTH-1:0]       nb_payload,
  input  wire  [pabq_pkg::SIZE_W-1:0]    nb_size,
  input  wire                            nb_prio,
  input  wire  pabq_pkg::cell_link_t     link_i,
  output pabq_pkg::cell_link_t           link_o,
  output logic [PAYLOAD_WIDTH-1:0]       payload_o,
  output logic [pabq_pkg::SIZE_W-1:0]    size_o,
  output logic                           prio_o
);

  logic [PAYLOAD_WIDTH-1:0]    payload_r, payload_nxt;
  logic [pabq_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic                        prio_r, prio_nxt;
  logic                        kill;

  // The first valid ordinary entry seen from the head is the victim.
  assign kill = ctl.evict_np & valid_i & ~prio_r & ~link_i.np_seen;

  always_comb begin
    link_o.np_seen = link_i.np_seen | (valid_i & ~prio_r);
    link_o.shift   = link_i.shift | kill;
    link_o.rm_size = kill ? size_r : link_i.rm_size;
  end

  always_comb begin
    payload_nxt = payload_r;
    size_nxt    = size_r;
    prio_nxt    = prio_r;
    if (wr_i) begin
      payload_nxt = wr_payload;
      size_nxt    = ctl.wr_size;
      prio_nxt    = ctl.wr_prio;
    end else if (link_o.shift) begin
      payload_nxt = nb_payload;
      size_nxt    = nb_size;
      prio_nxt    = nb_prio;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
    size_r    <= size_nxt;
    prio_r    <= prio_nxt;
  end

  assign payload_o = payload_r;
  assign size_o    = size_r;
  assign prio_o    = prio_r;

endmodule

`default_nettype wire

// ===== src/priority_aware_bounded_queue.sv =====
// ----------------------------------------------------------------------------
// priority_aware_bounded_queue: FIFO bounded by entry count and byte total
// Entries live in a row of cells with the head in cell 0. A push that does
// not fit evicts the oldest ordinary entry, one per cycle; with only priority
// entries left, a priority push evicts the head and an ordinary push is
// refused. Every eviction and refusal bumps a saturating drop counter.
//
//   channel | direction | handshake           | contents
//   --------+-----------+---------------------+-------------------------------
//   in_     | input     | in_tvalid/in_tready | command, payload, size, prio
//   out_    | output    | out_tvalid/out_tready| status, popped entry, counters
//   cfg_    | input     | cfg_valid/cfg_ready | register index and write data
//
// An item passes through accept, a decision state and a result load; a push
// repeats the decision state for each eviction, since the cell row moves by one
// entry per cycle. A new transaction is accepted once the previous result is
// loaded into the output register, even while that result still waits.
// If the output register is still full, the block holds the finished result
// until the downstream side takes it. Reset is synchronous and active low;
// the queue comes out of reset empty and closed.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_aware_bounded_queue #(
  parameter int DEPTH         = pabq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = pabq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // tdata: payload[31:0], size_bytes[51:32], zero fill [55:52]
  input  wire  [pabq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: command[1:0], is_priority[2]
  input  wire  [pabq_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // tdata: popped_payload[31:0], popped_size[51:32], occupancy[56:52],
  //        queued_total_bytes[80:57], drop_count[112:81], zero fill [119:113]
  output logic [pabq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: status[2:0]
  output logic [pabq_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [pabq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pabq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int ITEM_RST = (pabq_pkg::ITEM_LIMIT_RST > DEPTH) ? DEPTH
                                                              : pabq_pkg::ITEM_LIMIT_RST;
  localparam int SW = pabq_pkg::SIZE_W;
  localparam int BW = pabq_pkg::BYTES_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_OUT
  } state_t;

  state_t                            state_r, state_nxt;
  pabq_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [pabq_pkg::IN_PAY_W-1:0]     pay_r, pay_nxt;
  logic [SW-1:0]                     size_r, size_nxt;
  logic                              prio_r, prio_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [BW-1:0]                     bytes_r, bytes_nxt;
  logic [pabq_pkg::DROPS_W-1:0]      drops_r, drops_nxt;
  logic                              closed_r, closed_nxt;
  logic [CW-1:0]                     item_eff_r, item_eff_nxt;
  logic [BW-1:0]                     byte_eff_r, byte_eff_nxt;
  pabq_pkg::status_t                 res_status_r, res_status_nxt;
  logic [pabq_pkg::IN_PAY_W-1:0]     res_pp_r, res_pp_nxt;
  logic [SW-1:0]                     res_ps_r, res_ps_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [pabq_pkg::OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic [pabq_pkg::OUT_TUSER_W-1:0]  out_tuser_r, out_tuser_nxt;

  // Cell row signals.
  pabq_pkg::cell_ctl_t               ctl;
  pabq_pkg::cell_link_t              link [DEPTH+1];
  logic [PAYLOAD_WIDTH-1:0]          cell_pay [DEPTH+1];
  logic [SW-1:0]                     cell_size [DEPTH+1];
  logic                              cell_prio [DEPTH+1];
  logic [DEPTH-1:0]                  valid_vec;
  logic [DEPTH-1:0]                  wr_vec;

  logic                              evict_np;
  logic                              evict_head;
  logic                              do_write;
  logic [PAYLOAD_WIDTH-1:0]          wr_payload;
  logic [63:0]                       pay_ext;
  logic [63:0]                       head_ext;
  logic [BW:0]                       sum_bytes;
  logic                              too_large;
  logic                              fits;
  logic                              any_np;
  logic [SW-1:0]                     rm_size;
  logic [pabq_pkg::DROPS_W-1:0]      drops_inc;
  logic [pabq_pkg::ILIMIT_W-1:0]     ilim;
  logic [CW-1:0]                     item_cfg;

  // ---------------------------------------------------------------------------
  // Cell row. Cell 0 is the head; the slot past the tail feeds zeros.
  // A head removal enters the row as a shift from the head end.
  // ---------------------------------------------------------------------------
  assign pay_ext    = 64'(pay_r);
  assign wr_payload = pay_ext[PAYLOAD_WIDTH-1:0];

  always_comb begin
    ctl.evict_np = evict_np;
    ctl.wr_size  = size_r;
    ctl.wr_prio  = prio_r;
    link[0].np_seen = 1'b0;
    link[0].shift   = evict_head;
    link[0].rm_size = '0;
  end

  assign cell_pay[DEPTH]  = '0;
  assign cell_size[DEPTH] = '0;
  assign cell_prio[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_vec[i] = (count_r > CW'(i));
    assign wr_vec[i]    = do_write & (count_r == CW'(i));

    pabq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid_i   (valid_vec[i]),
      .wr_i      (wr_vec[i]),
      .wr_payload(wr_payload),
      .nb_payload(cell_pay[i+1]),
      .nb_size   (cell_size[i+1]),
      .nb_prio   (cell_prio[i+1]),
      .link_i    (link[i]),
      .link_o    (link[i+1]),
      .payload_o (cell_pay[i]),
      .size_o    (cell_size[i]),
      .prio_o    (cell_prio[i])
    );
  end

  assign any_np   = link[DEPTH].np_seen;
  assign rm_size  = evict_head ? cell_size[0] : link[DEPTH].rm_size;
  assign head_ext = 64'(cell_pay[0]);

  // ---------------------------------------------------------------------------
  // Push decision terms. The closed and size checks do not change while a
  // push evicts, so they are simply taken again in every work cycle.
  // ---------------------------------------------------------------------------
  assign too_large = BW'(size_r) > byte_eff_r;
  assign sum_bytes = {1'b0, bytes_r} + (BW + 1)'(size_r);
  assign fits      = (count_r < item_eff_r) && (sum_bytes <= {1'b0, byte_eff_r});
  assign drops_inc = (drops_r == '1) ? drops_r : drops_r + pabq_pkg::DROPS_W'(1);

  always_comb begin
    evict_np   = 1'b0;
    evict_head = 1'b0;
    do_write   = 1'b0;
    if (state_r == S_WORK) begin
      if (cmd_r == pabq_pkg::CMD_POP) begin
        evict_head = (count_r != '0);
      end else if (cmd_r == pabq_pkg::CMD_PUSH && !closed_r && !too_large) begin
        if (fits) begin
          do_write = 1'b1;
        end else if (any_np) begin
          evict_np = 1'b1;
        end else begin
          evict_head = prio_r && (count_r != '0);
        end
      end
    end
  end

  // Effective item limit for a configuration write: clamped to 1..DEPTH.
  assign ilim = cfg_data[pabq_pkg::ILIMIT_W-1:0];
  always_comb begin
    if (ilim == '0) begin
      item_cfg = CW'(1);
    end else if (32'(ilim) > DEPTH) begin
      item_cfg = CW'(DEPTH);
    end else begin
      item_cfg = CW'(ilim);
    end
  end

  // ---------------------------------------------------------------------------
  // Control sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pay_nxt        = pay_r;
    size_nxt       = size_r;
    prio_nxt       = prio_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    drops_nxt      = drops_r;
    closed_nxt     = closed_r;
    item_eff_nxt   = item_eff_r;
    byte_eff_nxt   = byte_eff_r;
    res_status_nxt = res_status_r;
    res_pp_nxt     = res_pp_r;
    res_ps_nxt     = res_ps_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    // The user must write configuration only while the queue is idle; the block itself does not enforce it.
    if (cfg_valid) begin
      if (cfg_index == pabq_pkg::CFG_ITEM_LIMIT) begin
        item_eff_nxt = item_cfg;
      end else if (cfg_index == pabq_pkg::CFG_BYTE_LIMIT) begin
        byte_eff_nxt = (cfg_data == '0) ? BW'(1) : cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = pabq_pkg::cmd_t'(in_tuser[1:0]);
          prio_nxt  = in_tuser[2];
          pay_nxt   = in_tdata[31:0];
          size_nxt  = in_tdata[51:32];
          state_nxt = S_WORK;
        end
      end

      S_WORK: begin
        res_pp_nxt     = '0;
        res_ps_nxt     = '0;
        res_status_nxt = pabq_pkg::ST_OK;
        state_nxt      = S_OUT;
        case (cmd_r)
          pabq_pkg::CMD_PUSH: begin
            if (closed_r) begin
              res_status_nxt = pabq_pkg::ST_CLOSED;
              drops_nxt      = drops_inc;
            end else if (too_large) begin
              res_status_nxt = pabq_pkg::ST_TOO_LARGE;
              drops_nxt      = drops_inc;
            end else if (do_write) begin
              count_nxt = count_r + CW'(1);
              bytes_nxt = sum_bytes[BW-1:0];
            end else if (evict_np || evict_head) begin
              // One eviction this cycle, then try again.
              count_nxt = count_r - CW'(1);
              bytes_nxt = bytes_r - BW'(rm_size);
              drops_nxt = drops_inc;
              state_nxt = S_WORK;
            end else begin
              res_status_nxt = pabq_pkg::ST_NO_ROOM;
              drops_nxt      = drops_inc;
            end
          end
          pabq_pkg::CMD_POP: begin
            if (evict_head) begin
              res_pp_nxt = head_ext[pabq_pkg::IN_PAY_W-1:0];
              res_ps_nxt = cell_size[0];
              count_nxt  = count_r - CW'(1);
              bytes_nxt  = bytes_r - BW'(rm_size);
            end else begin
              res_status_nxt = closed_r ? pabq_pkg::ST_EMPTY_CLOSED
                                        : pabq_pkg::ST_EMPTY_OPEN;
            end
          end
          pabq_pkg::CMD_OPEN: begin
            closed_nxt = 1'b0;
          end
          default: begin
            closed_nxt = 1'b1;
          end
        endcase
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {7'd0, drops_r, bytes_r,
                            pabq_pkg::OCC_W'(count_r), res_ps_r, res_pp_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      bytes_r      <= '0;
      drops_r      <= '0;
      closed_r     <= 1'b1;
      item_eff_r   <= CW'(ITEM_RST);
      byte_eff_r   <= BW'(pabq_pkg::BYTE_LIMIT_RST);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      drops_r      <= drops_nxt;
      closed_r     <= closed_nxt;
      item_eff_r   <= item_eff_nxt;
      byte_eff_r   <= byte_eff_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r        <= cmd_nxt;
    pay_r        <= pay_nxt;
    size_r       <= size_nxt;
    prio_r       <= prio_nxt;
    res_status_r <= res_status_nxt;
    res_pp_r     <= res_pp_nxt;
    res_ps_r     <= res_ps_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The queue never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds the number of cells");

  // An empty queue carries no bytes.
  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bytes_r == '0))
    else $error("byte total nonzero on an empty queue");

  // An eviction only happens while entries are present.
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (evict_np || evict_head) |-> (count_r != '0))
    else $error("eviction requested on an empty queue");

  // The drop counter never goes backward.
  a_drops_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (drops_r >= $past(drops_r)))
    else $error("drop counter decreased");

  // Only one transaction is in the works at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item was in progress");

endmodule

`default_nettype wire

// ===== tb/pabq_checker.sv =====
// ----------------------------------------------------------------------------
// pabq_checker: result predictor and comparator for the bounded queue
// Watches the input, result and configuration channels. Every accepted input
// transaction is run through a private copy of the queue and its expected
// result is stored. Every accepted result is compared field by field with
// the oldest stored result.
// ----------------------------------------------------------------------------

module pabq_checker (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [pabq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire  [pabq_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire                               in_tvalid,
  input  wire                               in_tready,
  input  wire  [pabq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire  [pabq_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  wire                               out_tvalid,
  input  wire                               out_tready,
  input  wire                               cfg_valid,
  input  wire                               cfg_ready,
  input  wire  [pabq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pabq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int unsigned                       n_pending,
  output int unsigned                       n_fail
);

  localparam int unsigned SLOTS = pabq_pkg::DEPTH_DEF;

  typedef struct packed {
    pabq_pkg::status_t              status;
    logic [31:0]                    pay;
    logic [pabq_pkg::SIZE_W-1:0]    size;
    logic [pabq_pkg::OCC_W-1:0]     occ;
    logic [pabq_pkg::BYTES_W-1:0]   bytes;
    logic [pabq_pkg::DROPS_W-1:0]   drops;
  } result_t;

  result_t             pending_results[$];
  result_t             want;
  result_t             got;

  // Shadow copy of the queue, head in slot 0.
  logic [31:0]                    slot_payload [SLOTS];
  logic [pabq_pkg::SIZE_W-1:0]    slot_size    [SLOTS];
  bit                             slot_prio    [SLOTS];
  int unsigned                    held;
  int unsigned                    held_bytes;
  logic [pabq_pkg::DROPS_W-1:0]   drops;
  bit                             shut;
  logic [pabq_pkg::ILIMIT_W-1:0]  item_lim;
  logic [pabq_pkg::BYTES_W-1:0]   byte_lim;
  int unsigned                    fails;

  function automatic void count_drop();
    if (drops != '1) drops = drops + pabq_pkg::DROPS_W'(1);
  endfunction

  function automatic void remove_entry(int unsigned idx);
    int unsigned i;
    held_bytes = held_bytes - slot_size[idx];
    for (i = idx; i + 1 < held; i++) begin
      slot_payload[i] = slot_payload[i + 1];
      slot_size[i]    = slot_size[i + 1];
      slot_prio[i]    = slot_prio[i + 1];
    end
    held = held - 1;
  endfunction

  function automatic result_t queue_step(pabq_pkg::cmd_t cmd, logic [31:0] pay,
                                         logic [pabq_pkg::SIZE_W-1:0] sz, bit pr);
    result_t     r;
    int unsigned cap_items;
    int unsigned cap_bytes;
    int unsigned idx;
    int unsigned i;
    bit          refused;
    r = '0;
    r.status = pabq_pkg::ST_OK;
    cap_items = (item_lim == 0) ? 1 : ((item_lim > SLOTS) ? SLOTS : item_lim);
    cap_bytes = (byte_lim == 0) ? 1 : byte_lim;
    case (cmd)
      pabq_pkg::CMD_PUSH: begin
        if (shut) begin
          count_drop();
          r.status = pabq_pkg::ST_CLOSED;
        end else if (sz > cap_bytes) begin
          count_drop();
          r.status = pabq_pkg::ST_TOO_LARGE;
        end else begin
          refused = 1'b0;
          while (!refused && !(held < cap_items && held_bytes + sz <= cap_bytes)) begin
            idx = held;
            for (i = held; i > 0; i--) begin
              if (!slot_prio[i - 1]) idx = i - 1;
            end
            if (idx < held) begin
              remove_entry(idx);
              count_drop();
            end else if (!pr || held == 0) begin
              count_drop();
              r.status = pabq_pkg::ST_NO_ROOM;
              refused = 1'b1;
            end else begin
              remove_entry(0);
              count_drop();
            end
          end
          if (!refused) begin
            slot_payload[held] = pay;
            slot_size[held]    = sz;
            slot_prio[held]    = pr;
            held       = held + 1;
            held_bytes = held_bytes + sz;
          end
        end
      end
      pabq_pkg::CMD_POP: begin
        if (held == 0) begin
          r.status = shut ? pabq_pkg::ST_EMPTY_CLOSED : pabq_pkg::ST_EMPTY_OPEN;
        end else begin
          r.pay  = slot_payload[0];
          r.size = slot_size[0];
          remove_entry(0);
        end
      end
      pabq_pkg::CMD_OPEN: shut = 1'b0;
      default:            shut = 1'b1;
    endcase
    r.occ   = held[pabq_pkg::OCC_W-1:0];
    r.bytes = held_bytes[pabq_pkg::BYTES_W-1:0];
    r.drops = drops;
    return r;
  endfunction

  function automatic int unsigned field_diff(string name, logic [31:0] exp_v,
                                             logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned k = 0; k < SLOTS; k++) begin
        slot_payload[k] = '0;
        slot_size[k]    = '0;
        slot_prio[k]    = 1'b0;
      end
      held       = 0;
      held_bytes = 0;
      drops      = '0;
      shut       = 1'b1;
      item_lim   = pabq_pkg::ILIMIT_W'(pabq_pkg::ITEM_LIMIT_RST);
      byte_lim   = pabq_pkg::BYTES_W'(pabq_pkg::BYTE_LIMIT_RST);
      fails      = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pabq_pkg::CFG_ITEM_LIMIT: item_lim = cfg_data[pabq_pkg::ILIMIT_W-1:0];
          pabq_pkg::CFG_BYTE_LIMIT: byte_lim = cfg_data[pabq_pkg::BYTES_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.status = pabq_pkg::status_t'(out_tuser[pabq_pkg::STATUS_W-1:0]);
        got.pay    = out_tdata[31:0];
        got.size   = out_tdata[51:32];
        got.occ    = out_tdata[56:52];
        got.bytes  = out_tdata[80:57];
        got.drops  = out_tdata[112:81];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d payload %0h",
                   $time, got.status, got.pay);
          fails++;
        end else begin
          // Oldest expectation first.
          want = pending_results[0];
          pending_results.delete(0);
          fails += field_diff("status", 32'(want.status), 32'(got.status));
          fails += field_diff("popped_payload", want.pay, got.pay);
          fails += field_diff("popped_size", 32'(want.size), 32'(got.size));
          fails += field_diff("occupancy", 32'(want.occ), 32'(got.occ));
          fails += field_diff("queued_total_bytes", 32'(want.bytes), 32'(got.bytes));
          fails += field_diff("drop_count", want.drops, got.drops);
        end
      end
      if (in_tvalid && in_tready) begin
        want = queue_step(pabq_pkg::cmd_t'(in_tuser[pabq_pkg::CMD_W-1:0]), in_tdata[31:0],
                          in_tdata[51:32], in_tuser[2]);
        pending_results.insert(pending_results.size(), want);
      end
    end
    n_pending <= pending_results.size();
    n_fail    <= fails;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the priority-aware bounded queue
// Drives a directed opening that walks through refusals, evictions, limit
// clamping and draining while closed, then several random phases under
// different limits. A separate checker predicts and compares every result;
// this module only drives the channels and reports the outcome.
// ----------------------------------------------------------------------------

module tb_top;

  // Cycles of quiet after the last result before reconfiguring or ending.
  // Covers an item's accept, decision and result load plus one eviction per queue slot.
  localparam int unsigned SETTLE         = 24;
  // Length of the long downstream hold-off used to back the block up.
  localparam int unsigned HOLD_CYCLES    = 300;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned RAND_PER_PHASE = 150;

  // Register indexes beyond the defined ones; writes to them must be ignored.
  localparam logic [pabq_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [pabq_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic [pabq_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [pabq_pkg::IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [pabq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [pabq_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [pabq_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [pabq_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  int unsigned n_pending;
  int unsigned n_fail;

  // When set, neither side idles: a stretch of back-to-back traffic.
  bit          calm;
  // Each increment asks the result side for one long hold-off.
  int unsigned hold_asks;
  // Byte limit currently programmed, used only to shape random sizes.
  int unsigned cur_blim;
  int unsigned quiet;

  always #10 clk = ~clk;

  priority_aware_bounded_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pabq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_pending  (n_pending),
    .n_fail     (n_fail)
  );

  // Watchdog: any cycle that moves a transaction on any channel resets it.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side. It normally stalls about one cycle in five, runs without
  // stalls while calm is set, and on request holds off for a long stretch
  // counted here, so the block fills up and pushes back on its input.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // Valid is left high so that a following transaction goes out back to
  // back; random gaps lower it first.
  task automatic offer(input pabq_pkg::cmd_t c, input logic [31:0] pay,
                       input logic [pabq_pkg::SIZE_W-1:0] sz, input bit pr);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, sz, pay};
    in_tuser  <= {pr, c};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every expected result has come back,
  // then lets the block settle so that it is idle for a register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register. Valid stays high for a following write; the
  // caller lowers it after the last one of a group.
  task automatic set_reg(input logic [pabq_pkg::CFG_IDX_W-1:0] idx,
                         input logic [pabq_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input int unsigned ilim, input int unsigned blim);
    drain();
    set_reg(pabq_pkg::CFG_ITEM_LIMIT, pabq_pkg::CFG_DATA_W'(ilim));
    set_reg(pabq_pkg::CFG_BYTE_LIMIT, pabq_pkg::CFG_DATA_W'(blim));
    cfg_valid <= 1'b0;
    cur_blim = (blim == 0) ? 1 : blim;
  endtask

  // One random transaction. Pushes dominate so the limits are reached
  // often; sizes are scaled to the byte limit so that evictions happen, with
  // some zero sizes, some too large and some fully random sizes mixed in.
  task automatic offer_random();
    int unsigned                 pick;
    int unsigned                 span;
    pabq_pkg::cmd_t              c;
    logic [pabq_pkg::SIZE_W-1:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 55) c = pabq_pkg::CMD_PUSH;
    else if (pick < 83) c = pabq_pkg::CMD_POP;
    else if (pick < 95) c = pabq_pkg::CMD_OPEN;
    else c = pabq_pkg::CMD_CLOSE;
    span = cur_blim / 3;
    if (span > 20'hFFFFF) span = 20'hFFFFF;
    if (span == 0) span = 1;
    pick = $urandom_range(0, 99);
    if (pick < 8) sz = '0;
    else if (pick < 14) sz = pabq_pkg::SIZE_W'($urandom_range(0, 20'hFFFFF));
    else if (pick < 20) sz = (cur_blim < 20'hFFFFF) ? pabq_pkg::SIZE_W'(cur_blim + 1)
                                                    : 20'hFFFFF;
    else sz = pabq_pkg::SIZE_W'($urandom_range(1, span));
    offer(c, $urandom, sz, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    calm      = 1'b0;
    hold_asks = 0;
    cur_blim  = pabq_pkg::BYTE_LIMIT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits, queue starts closed. Empty pops report the open or closed state,
    // a closed queue refuses pushes before looking at the size, and a push
    // that needs room evicts every ordinary entry in front of it.
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'hFFFFFFFF, 20'hFFFFF, 1'b1);
    offer(pabq_pkg::CMD_OPEN,  32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h12345678, 20'hFFFFF, 1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'hFFFFFFFF, 20'h0,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000000, 20'h10000, 1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'hA5A5A5A5, 20'h1,     1'b1);
    // A closed queue still drains.
    offer(pabq_pkg::CMD_CLOSE, 32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);

    // Two slots: with only priority entries left an ordinary push is refused
    // and a priority push evicts the head.
    reconfigure(2, 100);
    offer(pabq_pkg::CMD_OPEN,  32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000011, 20'd10,    1'b1);
    offer(pabq_pkg::CMD_PUSH,  32'h00000022, 20'd10,    1'b1);
    offer(pabq_pkg::CMD_PUSH,  32'h00000033, 20'd10,    1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000044, 20'd10,    1'b1);
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000055, 20'd5,     1'b0);

    // Byte limit lowered below the contents, item limit above its range.
    // The first push evicts the ordinary entry and is refused anyway; the
    // eviction stands.
    reconfigure(31, 12);
    offer(pabq_pkg::CMD_PUSH,  32'h00000066, 20'd3,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000077, 20'd12,    1'b1);
    offer(pabq_pkg::CMD_PUSH,  32'h00000088, 20'd13,    1'b1);
    offer(pabq_pkg::CMD_POP,   32'h0,        20'h0,     1'b0);

    // Zero limits clamp to one entry and one byte.
    reconfigure(0, 0);
    offer(pabq_pkg::CMD_PUSH,  32'h00000099, 20'd1,     1'b0);
    offer(pabq_pkg::CMD_PUSH,  32'h000000AA, 20'd1,     1'b1);
    offer(pabq_pkg::CMD_PUSH,  32'h000000BB, 20'd0,     1'b0);

    // Widest byte limit; writes to undefined indexes must change nothing.
    reconfigure(16, 24'hFFFFFF);
    @(posedge clk);
    set_reg(CFG_SPARE_LO, '0);
    set_reg(CFG_SPARE_HI, '0);
    cfg_valid <= 1'b0;
    offer(pabq_pkg::CMD_PUSH,  32'h5A5A5A5A, 20'hFFFFF, 1'b0);

    // Random phases, each under its own limits.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: reconfigure(4, 1000);
        1: reconfigure(16, 24'hFFFFFF);
        2: reconfigure(1, 1);
        3: reconfigure(31, 300);
        4: reconfigure($urandom_range(0, 31), $urandom_range(0, 24'hFFFFFF));
        default: reconfigure($urandom_range(2, 8), $urandom_range(16, 4096));
      endcase
      // Phase one runs without any idling on either side.
      calm = (ph == 1);
      if (ph == 3) hold_asks++;
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 3 && n == RAND_PER_PHASE / 2) hold_asks++;
        offer_random();
      end
      calm = 1'b0;
    end

    drain();
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
